>>> src/arpc_pkg.sv
// Shared types and constants for the ARP cache with aging.
package arpc_pkg;

   localparam int ENTRIES   = 16;
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int IP_W      = 32;
   localparam int MAC_W     = 48;
   localparam int AGE_W     = 16;
   localparam int EXP_W     = 5;
   localparam logic [EXP_W-1:0] EXP_MAX     = 5'd31;
   localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 16'd300;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_TICK   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ADDED = 2'd1,
      ST_MISS  = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
      logic [AGE_W-1:0] age;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      op_type           operation;
      logic [IP_W-1:0]  ip_addr;
      logic [MAC_W-1:0] mac_addr;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [MAC_W-1:0] mac_out;
      status_type       status;
      logic [EXP_W-1:0] expired_count;
   } res_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      row_type          wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } ram_req_type;

endpackage

>>> src/arpc_if.sv
// Request and response channel interfaces.
interface arpc_req_if;
   import arpc_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       operation;
   logic [IP_W-1:0]  ip_addr;
   logic [MAC_W-1:0] mac_addr;

   modport source (output valid, output operation, output ip_addr, output mac_addr,
                   input ready);
   modport sink   (input valid, input operation, input ip_addr, input mac_addr,
                   output ready);
endinterface

interface arpc_rsp_if;
   import arpc_pkg::*;
   logic             valid;
   logic             ready;
   logic             found;
   logic [MAC_W-1:0] mac_out;
   logic [1:0]       status;
   logic [EXP_W-1:0] expired_count;

   modport source (output valid, output found, output mac_out, output status,
                   output expired_count, input ready);
   modport sink   (input valid, input found, input mac_out, input status,
                   input expired_count, output ready);
endinterface

>>> src/arpc_ram.sv
// Simple dual-port synchronous RAM, registered read.
module arpc_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 96,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/arpc_ctrl.sv
// Operation sequencer: scans the entry memory, keeps valid bits, forms results.
module arpc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  arpc_pkg::req_type          req,
   input  logic [arpc_pkg::AGE_W-1:0] age_limit,
   output arpc_pkg::ram_req_type      ram,
   input  arpc_pkg::row_type          ram_rdata,
   output logic                       res_valid,
   input  logic                       res_ready,
   output arpc_pkg::res_type          res
);
   import arpc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD, S_DONE} state_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [IP_W-1:0]    ip_ff, ip_in;
   logic [MAC_W-1:0]   mac_ff, mac_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               chk_ff, chk_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [MAC_W-1:0]   hit_mac_ff, hit_mac_in;
   logic [AGE_W-1:0]   hit_age_ff, hit_age_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [EXP_W-1:0]   exp_ff, exp_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   res_type            res_ff, res_in;
   logic               cur_valid;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      ip_in       = ip_ff;
      mac_in      = mac_ff;
      cnt_in      = cnt_ff;
      chk_in      = 1'b0;
      chk_idx_in  = chk_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_mac_in  = hit_mac_ff;
      hit_age_in  = hit_age_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      exp_in      = exp_ff;
      valid_in    = valid_ff;
      res_in      = res_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ram         = '0;
      cur_valid   = valid_ff[chk_idx_ff];

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req.operation;
               ip_in    = req.ip_addr;
               mac_in   = req.mac_addr;
               cnt_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               exp_in   = '0;
               state_in = (req.operation == OP_CLEAR) ? S_UPD : S_SCAN;
            end
         end
         S_SCAN: begin
            // read entry cnt, check the entry read last cycle
            ram.re    = (cnt_ff < CNT_W'(ENTRIES));
            ram.raddr = cnt_ff[IDX_W-1:0];
            chk_in    = ram.re;
            chk_idx_in = cnt_ff[IDX_W-1:0];
            if (ram.re) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               state_in = S_UPD;
            end
            if (chk_ff) begin
               if (op_ff == OP_TICK) begin
                  if (cur_valid) begin
                     if (ram_rdata.age == '0) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        if (exp_ff != EXP_MAX) begin
                           exp_in = exp_ff + EXP_W'(1);
                        end
                     end else begin
                        ram.we    = 1'b1;
                        ram.waddr = chk_idx_ff;
                        ram.wdata = '{ip: ram_rdata.ip, mac: ram_rdata.mac,
                                      age: ram_rdata.age - AGE_W'(1)};
                     end
                  end
               end else begin
                  if (cur_valid && ram_rdata.ip == ip_ff && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = chk_idx_ff;
                     hit_mac_in = ram_rdata.mac;
                     hit_age_in = ram_rdata.age;
                  end
                  if (!cur_valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
               end
            end
         end
         S_UPD: begin
            res_in   = '{found: 1'b0, mac_out: '0, status: ST_OK, expired_count: '0};
            state_in = S_DONE;
            case (op_ff)
               OP_INSERT: begin
                  if (hit_ff) begin
                     ram.we        = 1'b1;
                     ram.waddr     = hit_idx_ff;
                     ram.wdata     = '{ip: ip_ff, mac: mac_ff, age: hit_age_ff};
                     res_in.found  = 1'b1;
                  end else if (free_ff) begin
                     ram.we        = 1'b1;
                     ram.waddr     = free_idx_ff;
                     ram.wdata     = '{ip: ip_ff, mac: mac_ff, age: age_limit};
                     valid_in[free_idx_ff] = 1'b1;
                     res_in.status = ST_ADDED;
                  end else begin
                     res_in.status = ST_FULL;
                  end
               end
               OP_LOOKUP: begin
                  if (hit_ff) begin
                     res_in.found   = 1'b1;
                     res_in.mac_out = hit_mac_ff;
                  end else begin
                     res_in.status  = ST_MISS;
                  end
               end
               OP_TICK: begin
                  res_in.expired_count = exp_ff;
               end
               OP_CLEAR: begin
                  valid_in = '0;
               end
               default: begin
                  res_in.status = ST_OK;
               end
            endcase
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         chk_ff   <= chk_in;
      end
      op_ff       <= op_in;
      ip_ff       <= ip_in;
      mac_ff      <= mac_in;
      cnt_ff      <= cnt_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_mac_ff  <= hit_mac_in;
      hit_age_ff  <= hit_age_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      exp_ff      <= exp_in;
      res_ff      <= res_in;
   end

   assign res = res_ff;

endmodule

>>> src/arp_cache_with_aging.sv
// Top level of the ARP cache with aging: channels, age limit register, output stage.
// Each request is handled one at a time. Insert, lookup and tick scan the whole
// entry memory, one entry per cycle through its single read port; clear skips the scan.
// The result sits in an output register, so the next request is accepted while a
// result still waits. Age limit writes are taken at any time and should be made
// while the block is idle.
module arp_cache_with_aging (
   input  logic                       clock,
   input  logic                       reset,
   arpc_req_if.sink                   req_if,
   arpc_rsp_if.source                 rsp_if,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [arpc_pkg::AGE_W-1:0] csr_wdata
);
   import arpc_pkg::*;

   logic [AGE_W-1:0] age_limit_ff;
   ram_req_type      ram;
   row_type          ram_rdata;
   logic [ROW_W-1:0] rdata_raw;
   req_type          req;
   res_type          res;
   logic             res_valid;
   logic             res_ready;
   logic             rsp_valid_ff;
   res_type          rsp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_LIMIT_RST;
      end else if (csr_valid) begin
         age_limit_ff <= csr_wdata;
      end
   end

   assign req = '{operation: op_type'(req_if.operation),
                  ip_addr:   req_if.ip_addr,
                  mac_addr:  req_if.mac_addr};

   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req       (req),
      .age_limit (age_limit_ff),
      .ram       (ram),
      .ram_rdata (ram_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   arpc_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (ROW_W),
      .AW    (IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (ram.we),
      .waddr (ram.waddr),
      .wdata (ram.wdata),
      .re    (ram.re),
      .raddr (ram.raddr),
      .rdata (rdata_raw)
   );

   assign ram_rdata = row_type'(rdata_raw);

   // output register: free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.found         = rsp_ff.found;
   assign rsp_if.mac_out       = rsp_ff.mac_out;
   assign rsp_if.status        = rsp_ff.status;
   assign rsp_if.expired_count = rsp_ff.expired_count;

endmodule

>>> test/arp_cache_with_aging_test.sv
// Self-checking testbench for the ARP cache with aging: directed, random and back-pressure runs.
module arp_cache_with_aging_test;
   timeunit 1ns;
   timeprecision 1ps;
   import arpc_pkg::*;

   localparam int POOL_SIZE    = 24;
   localparam int HOLD_LEN     = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;

   logic clock = 1'b0;
   logic reset;

   logic             csr_valid;
   logic             csr_ready;
   logic [AGE_W-1:0] csr_wdata;

   arpc_req_if req_ch ();
   arpc_rsp_if rsp_ch ();

   arp_cache_with_aging i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #5ns clock = ~clock;

   // Local copy of the binding table and the age limit register.
   logic             bind_valid [ENTRIES];
   logic [IP_W-1:0]  bind_ip    [ENTRIES];
   logic [MAC_W-1:0] bind_mac   [ENTRIES];
   logic [AGE_W-1:0] bind_age   [ENTRIES];
   logic [AGE_W-1:0] cur_age_limit;

   res_type pending_results[$];

   logic [IP_W-1:0] ip_pool [POOL_SIZE];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int          hold_serial = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          errors = 0;
   int          stall_cycles = 0;

   function automatic res_type cache_apply(op_type op, logic [IP_W-1:0] ip,
                                           logic [MAC_W-1:0] mac);
      res_type r;
      int      hit;
      int      slot;
      r    = '0;
      hit  = -1;
      slot = -1;
      for (int k = 0; k < ENTRIES; k++) begin
         if (hit < 0 && bind_valid[k] && bind_ip[k] == ip) hit = k;
         if (slot < 0 && !bind_valid[k]) slot = k;
      end
      case (op)
         OP_INSERT: begin
            if (hit >= 0) begin
               bind_mac[hit] = mac;
               r.found       = 1'b1;
            end else if (slot < 0) begin
               r.status = ST_FULL;
            end else begin
               bind_valid[slot] = 1'b1;
               bind_ip[slot]    = ip;
               bind_mac[slot]   = mac;
               bind_age[slot]   = cur_age_limit;
               r.status         = ST_ADDED;
            end
         end
         OP_LOOKUP: begin
            if (hit >= 0) begin
               r.found   = 1'b1;
               r.mac_out = bind_mac[hit];
            end else begin
               r.status = ST_MISS;
            end
         end
         OP_TICK: begin
            for (int k = 0; k < ENTRIES; k++) begin
               if (bind_valid[k]) begin
                  if (bind_age[k] == '0) begin
                     bind_valid[k] = 1'b0;
                     if (r.expired_count != EXP_MAX) r.expired_count++;
                  end else begin
                     bind_age[k] = bind_age[k] - 1'b1;
                  end
               end
            end
         end
         default: begin
            for (int k = 0; k < ENTRIES; k++) bind_valid[k] = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      return {16'($urandom), $urandom};
   endfunction

   // One request beat. valid stays high after the beat so that back-to-back
   // items need no second assignment in the same step.
   task automatic send_req(op_type op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(24, 1);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.ip_addr   <= ip;
      req_ch.mac_addr  <= mac;
      do @(posedge clock); while (!req_ch.ready);
      pending_results = {pending_results, cache_apply(op, ip, mac)};
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_age_limit(logic [AGE_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      cur_age_limit = value;
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int count, int w_insert, int w_lookup, int w_tick);
      int              pick;
      op_type          op;
      logic [IP_W-1:0] ip;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < w_insert) op = OP_INSERT;
         else if (pick < w_insert + w_lookup) op = OP_LOOKUP;
         else if (pick < w_insert + w_lookup + w_tick) op = OP_TICK;
         else op = OP_CLEAR;
         // mostly keys from a small pool so that hits, updates and a full table occur
         if ($urandom_range(9) == 0) ip = $urandom;
         else ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
         send_req(op, ip, rand_mac());
      end
   endtask

   task automatic test_directed();
      write_age_limit('0);
      send_req(OP_LOOKUP, '0, rand_mac());
      send_req(OP_TICK, $urandom, rand_mac());
      send_req(OP_INSERT, '0, '0);
      send_req(OP_INSERT, '0, '1);
      send_req(OP_LOOKUP, '0, '0);
      for (int k = 0; k < ENTRIES - 2; k++) send_req(OP_INSERT, 32'hC0A8_0001 + k, rand_mac());
      send_req(OP_INSERT, '1, rand_mac());
      send_req(OP_INSERT, 32'h0000_0001, rand_mac());
      // age limit zero: the whole full table goes on the next tick
      send_req(OP_TICK, '0, '0);
      send_req(OP_INSERT, '1, '1);
      send_req(OP_CLEAR, '1, '1);
      send_req(OP_LOOKUP, '1, '0);
   endtask

   task automatic test_long_age();
      write_age_limit('1);
      run_random(365, 45, 40, 13);
   endtask

   task automatic test_zero_age();
      write_age_limit('0);
      run_random(365, 45, 40, 13);
   endtask

   task automatic test_backpressure();
      write_age_limit(AGE_LIMIT_RST);
      hold_serial++;
      run_random(24, 50, 40, 10);
   endtask

   task automatic test_short_age();
      write_age_limit(AGE_W'($urandom_range(6, 1)));
      run_random(365, 40, 35, 23);
   endtask

   // result receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_seen = hold_serial;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      res_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            if (errors < MAX_REPORTS)
               $display("unexpected result beat: found=%0b mac=%h status=%0d expired=%0d",
                        rsp_ch.found, rsp_ch.mac_out, rsp_ch.status, rsp_ch.expired_count);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.found !== want.found || rsp_ch.mac_out !== want.mac_out ||
                rsp_ch.status !== want.status ||
                rsp_ch.expired_count !== want.expired_count) begin
               if (errors < MAX_REPORTS)
                  $display({"mismatch: expected found=%0b mac=%h status=%0d expired=%0d, ",
                            "got found=%0b mac=%h status=%0d expired=%0d"},
                           want.found, want.mac_out, want.status, want.expired_count,
                           rsp_ch.found, rsp_ch.mac_out, rsp_ch.status,
                           rsp_ch.expired_count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_INSERT;
      req_ch.ip_addr   <= '0;
      req_ch.mac_addr  <= '0;
      csr_valid        <= 1'b0;
      csr_wdata        <= '0;
      cur_age_limit = AGE_LIMIT_RST;
      for (int k = 0; k < ENTRIES; k++) begin
         bind_valid[k] = 1'b0;
         bind_ip[k]    = '0;
         bind_mac[k]   = '0;
         bind_age[k]   = '0;
      end
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) ip_pool[k] = $urandom;

      send_idle_pct = 25;
      recv_idle_pct = 45;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_long_age();
      send_idle_pct = 45;
      recv_idle_pct = 25;
      test_zero_age();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_short_age();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
src/arpc_pkg.sv
src/arpc_if.sv
src/arpc_ram.sv
src/arpc_ctrl.sv
src/arp_cache_with_aging.sv
test/arp_cache_with_aging_test.sv
